FILE: design/spo2_pkg.sv
// ----------------------------------------------------------------------------
// spo2_pkg
// Shared types and constants of the ratio-of-ratios saturation estimator.
// ----------------------------------------------------------------------------
package spo2_pkg;

   localparam int WINDOW_DEPTH = 128;
   localparam int AVG_DEPTH    = 8;
   localparam int SAMPLE_BITS  = 18;

   localparam int WIN_AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
   localparam int PROD_W  = SAMPLE_BITS + SUM_W;
   localparam int AVG_AW  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int AVG_CW  = $clog2(AVG_DEPTH + 1);
   localparam int VAL_W   = 15;
   localparam int MEAN_W  = VAL_W + AVG_CW;
   localparam int CAL_W   = 16;

   localparam logic [CAL_W-1:0] SPO2_MIN = 16'd17920;
   localparam logic [CAL_W-1:0] SPO2_MAX = 16'd25600;
   localparam logic [CAL_W-1:0] INTERCEPT_RESET = 16'd28160;
   localparam logic [CAL_W-1:0] SLOPE_RESET     = 16'd3456;

   localparam logic REQ_SAMPLE   = 1'b0;
   localparam logic REQ_ESTIMATE = 1'b1;

   localparam logic [1:0] ST_STORED   = 2'd0;
   localparam logic [1:0] ST_ESTIMATE = 2'd1;
   localparam logic [1:0] ST_NOT_FULL = 2'd2;
   localparam logic [1:0] ST_ZERO_DC  = 2'd3;

   localparam logic CSR_INTERCEPT = 1'b0;
   localparam logic CSR_SLOPE     = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [SAMPLE_BITS-1:0] red_sample;
      logic [SAMPLE_BITS-1:0] ir_sample;
   } req_type_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             window_full;
      logic [VAL_W-1:0] spo2_avg;
   } rsp_type;

   typedef struct packed {
      logic         valid;
      logic         estimate;
      req_type_type item;
   } queue_out_type;

endpackage

FILE: design/spo2_ram.sv
// ----------------------------------------------------------------------------
// spo2_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spo2_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/spo2_div.sv
// ----------------------------------------------------------------------------
// spo2_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spo2_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [spo2_pkg::PROD_W-1:0]  dividend,
   input  logic [spo2_pkg::PROD_W-1:0]  divisor,
   output logic                         done,
   output logic [spo2_pkg::PROD_W-1:0]  quotient,
   output logic [spo2_pkg::PROD_W-1:0]  remainder
);
   import spo2_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] den_ff, den_in;
   logic [PROD_W:0]   trial;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      if (start) begin
         cnt_in = CNT_W'(PROD_W);
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = PROD_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[PROD_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

FILE: design/spo2_front.sv
// ----------------------------------------------------------------------------
// spo2_front
// Accepts request transactions, classifies them and queues them.
// ----------------------------------------------------------------------------
module spo2_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  spo2_pkg::req_type_type       req_payload,
   output spo2_pkg::queue_out_type      queue_out,
   input  logic                         queue_pop
);
   import spo2_pkg::*;

   typedef struct packed {
      logic         estimate;
      req_type_type item;
   } entry_type;

   entry_type   mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = queue_pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{estimate: (req_payload.req_type == REQ_ESTIMATE),
                                item: req_payload};
      end
   end

   assign queue_out.valid    = (count_ff != 2'd0);
   assign queue_out.estimate = mem_ff[rd_ptr_ff].estimate;
   assign queue_out.item     = mem_ff[rd_ptr_ff].item;
endmodule

FILE: design/spo2_back.sv
// ----------------------------------------------------------------------------
// spo2_back
// Executes queued transactions: window storage, scan, ratio and averaging.
// ----------------------------------------------------------------------------
module spo2_back (
   input  logic                          clock,
   input  logic                          reset,
   input  spo2_pkg::queue_out_type       queue_out,
   output logic                          queue_pop,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [spo2_pkg::CAL_W-1:0]    csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output spo2_pkg::rsp_type             rsp_payload
);
   import spo2_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_MF    = 4'd5;
   localparam logic [3:0] S_FINAL = 4'd6;
   localparam logic [3:0] S_PUSH  = 4'd7;
   localparam logic [3:0] S_MEAN  = 4'd8;
   localparam logic [3:0] S_MDIV  = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [CAL_W-1:0]       icpt_ff, icpt_in;
   logic [CAL_W-1:0]       slope_ff, slope_in;
   logic [WIN_AW-1:0]      wpos_ff, wpos_in;
   logic                   wwrap_ff, wwrap_in;
   logic [AVG_AW-1:0]      epos_ff, epos_in;
   logic                   ewrap_ff, ewrap_in;
   logic [VAL_W-1:0]       ring_ff [AVG_DEPTH];
   logic                   ring_we;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [WIN_AW:0]        scan_cnt_ff, scan_cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rd_first_ff, rd_first_in;
   logic [SUM_W-1:0]       rsum_ff, rsum_in, isum_ff, isum_in;
   logic [SAMPLE_BITS-1:0] rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [SAMPLE_BITS-1:0] imin_ff, imin_in, imax_ff, imax_in;

   logic [PROD_W-1:0]      num_ff, num_in, den_ff, den_in;
   logic [2*CAL_W-1:0]     psq_ff, psq_in;
   logic [PROD_W:0]        acc_ff, acc_in;
   logic [CAL_W-1:0]       res_ff, res_in;
   logic [3:0]             bit_ff, bit_in;
   logic                   ph_ff, ph_in;
   logic [VAL_W-1:0]       val_ff, val_in;
   logic [AVG_CW-1:0]      cnt_ff, cnt_in, idx_ff, idx_in;
   logic [MEAN_W-1:0]      msum_ff, msum_in;

   logic                   ram_we;
   logic [SAMPLE_BITS-1:0] red_rd, ir_rd;
   logic                   div_start, div_done;
   logic [PROD_W-1:0]      div_a, div_b, div_q, div_r;
   logic [PROD_W:0]        tmp;
   logic [2*CAL_W:0]       t_sum;
   logic [CAL_W-1:0]       diff;
   logic [SAMPLE_BITS-1:0] rrange, irange;

   spo2_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_red_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data (queue_out.item.red_sample),
      .rd_addr (scan_cnt_ff[WIN_AW-1:0]),
      .rd_data (red_rd)
   );

   spo2_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_ir_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data (queue_out.item.ir_sample),
      .rd_addr (scan_cnt_ff[WIN_AW-1:0]),
      .rd_data (ir_rd)
   );

   spo2_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign rrange    = rmax_ff - rmin_ff;
   assign irange    = imax_ff - imin_ff;
   assign div_start = ((state_ff == S_MUL) && (slope_ff != '0)) ||
                      ((state_ff == S_MEAN) && (idx_ff == cnt_ff));
   assign div_a     = (state_ff == S_MEAN) ? PROD_W'(msum_ff) : num_ff;
   assign div_b     = (state_ff == S_MEAN) ? PROD_W'(cnt_ff) : den_ff;
   assign queue_pop = (state_ff == S_IDLE) && !rsp_valid_ff && queue_out.valid;
   assign ram_we    = queue_pop && !queue_out.estimate;

   always_comb begin
      state_in     = state_ff;
      icpt_in      = icpt_ff;
      slope_in     = slope_ff;
      wpos_in      = wpos_ff;
      wwrap_in     = wwrap_ff;
      epos_in      = epos_ff;
      ewrap_in     = ewrap_ff;
      ring_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_first_in  = 1'b0;
      rsum_in      = rsum_ff;
      isum_in      = isum_ff;
      rmin_in      = rmin_ff;
      rmax_in      = rmax_ff;
      imin_in      = imin_ff;
      imax_in      = imax_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      psq_in       = psq_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      ph_in        = ph_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      msum_in      = msum_ff;
      tmp          = '0;
      t_sum        = '0;
      diff         = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INTERCEPT: icpt_in  = csr_wr_data;
            CSR_SLOPE:     slope_in = csr_wr_data;
            default:       icpt_in  = icpt_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (queue_pop) begin
               if (!queue_out.estimate) begin
                  if (wpos_ff == WIN_AW'(WINDOW_DEPTH - 1)) begin
                     wpos_in  = '0;
                     wwrap_in = 1'b1;
                  end else begin
                     wpos_in = wpos_ff + 1'b1;
                  end
                  rsp_in       = '{status: ST_STORED,
                                   window_full: (wwrap_ff ||
                                      (wpos_ff == WIN_AW'(WINDOW_DEPTH - 1))),
                                   spo2_avg: '0};
                  rsp_valid_in = 1'b1;
               end else if (!wwrap_ff) begin
                  rsp_in       = '{status: ST_NOT_FULL, window_full: 1'b0,
                                   spo2_avg: '0};
                  rsp_valid_in = 1'b1;
               end else begin
                  scan_cnt_in = '0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff != (WIN_AW + 1)'(WINDOW_DEPTH)) begin
               rd_vld_in   = 1'b1;
               rd_first_in = (scan_cnt_ff == '0);
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = S_CHECK;
            end
            if (rd_vld_ff) begin
               if (rd_first_ff) begin
                  rsum_in = SUM_W'(red_rd);
                  isum_in = SUM_W'(ir_rd);
                  rmin_in = red_rd;
                  rmax_in = red_rd;
                  imin_in = ir_rd;
                  imax_in = ir_rd;
               end else begin
                  rsum_in = rsum_ff + SUM_W'(red_rd);
                  isum_in = isum_ff + SUM_W'(ir_rd);
                  if (red_rd < rmin_ff) rmin_in = red_rd;
                  if (red_rd > rmax_ff) rmax_in = red_rd;
                  if (ir_rd < imin_ff) imin_in = ir_rd;
                  if (ir_rd > imax_ff) imax_in = ir_rd;
               end
            end
         end
         S_CHECK: begin
            if ((rsum_ff == '0) || (isum_ff == '0)) begin
               rsp_in       = '{status: ST_ZERO_DC, window_full: 1'b1,
                                spo2_avg: '0};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (irange == '0) begin
               val_in   = VAL_W'(SPO2_MIN);
               state_in = S_PUSH;
            end else begin
               num_in   = PROD_W'(rrange) * PROD_W'(isum_ff);
               den_in   = PROD_W'(rsum_ff) * PROD_W'(irange);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (slope_ff == '0) begin
               psq_in   = '0;
               res_in   = '0;
               state_in = S_FINAL;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (div_q[PROD_W-1:CAL_W] != '0) begin
                  val_in   = VAL_W'(SPO2_MIN);
                  state_in = S_PUSH;
               end else begin
                  psq_in   = slope_ff * div_q[CAL_W-1:0];
                  acc_in   = '0;
                  res_in   = '0;
                  bit_in   = 4'd15;
                  ph_in    = 1'b0;
                  state_in = S_MF;
               end
            end
         end
         S_MF: begin
            if (!ph_ff) begin
               tmp = {acc_ff[PROD_W-1:0], 1'b0};
               if (tmp >= {1'b0, den_ff}) begin
                  acc_in = tmp - {1'b0, den_ff};
                  res_in = {res_ff[CAL_W-2:0], 1'b1};
               end else begin
                  acc_in = tmp;
                  res_in = {res_ff[CAL_W-2:0], 1'b0};
               end
               ph_in = 1'b1;
            end else begin
               if (slope_ff[bit_ff]) begin
                  tmp = acc_ff + {1'b0, div_r};
                  if (tmp >= {1'b0, den_ff}) begin
                     acc_in = tmp - {1'b0, den_ff};
                     res_in = res_ff + 1'b1;
                  end else begin
                     acc_in = tmp;
                  end
               end
               ph_in = 1'b0;
               if (bit_ff == 4'd0) begin
                  state_in = S_FINAL;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end
         end
         S_FINAL: begin
            t_sum = {1'b0, psq_ff} + (2 * CAL_W + 1)'(res_ff);
            if (t_sum >= (2 * CAL_W + 1)'(icpt_ff)) begin
               val_in = VAL_W'(SPO2_MIN);
            end else begin
               diff = icpt_ff - t_sum[CAL_W-1:0];
               if (diff < SPO2_MIN) begin
                  val_in = VAL_W'(SPO2_MIN);
               end else if (diff > SPO2_MAX) begin
                  val_in = VAL_W'(SPO2_MAX);
               end else begin
                  val_in = diff[VAL_W-1:0];
               end
            end
            state_in = S_PUSH;
         end
         S_PUSH: begin
            ring_we = 1'b1;
            if (epos_ff == AVG_AW'(AVG_DEPTH - 1)) begin
               epos_in  = '0;
               ewrap_in = 1'b1;
               cnt_in   = AVG_CW'(AVG_DEPTH);
            end else begin
               epos_in = epos_ff + 1'b1;
               cnt_in  = ewrap_ff ? AVG_CW'(AVG_DEPTH) : AVG_CW'(epos_ff) + 1'b1;
            end
            idx_in   = '0;
            msum_in  = '0;
            state_in = S_MEAN;
         end
         S_MEAN: begin
            if (idx_ff == cnt_ff) begin
               state_in = S_MDIV;
            end else begin
               msum_in = msum_ff + MEAN_W'(ring_ff[idx_ff[AVG_AW-1:0]]);
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_MDIV: begin
            if (div_done) begin
               rsp_in       = '{status: ST_ESTIMATE, window_full: 1'b1,
                                spo2_avg: div_q[VAL_W-1:0]};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         icpt_ff      <= INTERCEPT_RESET;
         slope_ff     <= SLOPE_RESET;
         wpos_ff      <= '0;
         wwrap_ff     <= 1'b0;
         epos_ff      <= '0;
         ewrap_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_first_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         icpt_ff      <= icpt_in;
         slope_ff     <= slope_in;
         wpos_ff      <= wpos_in;
         wwrap_ff     <= wwrap_in;
         epos_ff      <= epos_in;
         ewrap_ff     <= ewrap_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         rd_first_ff  <= rd_first_in;
      end
      if (ring_we) begin
         ring_ff[epos_ff] <= val_ff;
      end
      rsp_ff      <= rsp_in;
      scan_cnt_ff <= scan_cnt_in;
      rsum_ff     <= rsum_in;
      isum_ff     <= isum_in;
      rmin_ff     <= rmin_in;
      rmax_ff     <= rmax_in;
      imin_ff     <= imin_in;
      imax_ff     <= imax_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      psq_ff      <= psq_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      ph_ff       <= ph_in;
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      msum_ff     <= msum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

FILE: design/spo2_ratio_estimator_unit.sv
// ----------------------------------------------------------------------------
// spo2_ratio_estimator_unit
// Ratio-of-ratios saturation estimator with a queued front and a sequencer.
// ----------------------------------------------------------------------------
// A sample transaction writes one red/IR pair into two 128-entry window RAMs;
// its response is registered after the queue pops it, and the next queued
// transaction starts only once that response has been taken. An estimate
// transaction runs a RAM scan of both windows, the ratio division, a
// fractional slope product and the ring mean; the ratio division and the
// ring mean share one bit-serial divider. A flat IR window skips the
// division and the product. A two-entry queue accepts new transactions
// while the sequencer works and while a result waits on the output register.
// ----------------------------------------------------------------------------
module spo2_ratio_estimator_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  spo2_pkg::req_type_type     req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output spo2_pkg::rsp_type          rsp_payload,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [spo2_pkg::CAL_W-1:0] csr_wr_data
);
   import spo2_pkg::*;

   queue_out_type queue_out;
   logic          queue_pop;

   spo2_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_out   (queue_out),
      .queue_pop   (queue_pop)
   );

   spo2_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_out   (queue_out),
      .queue_pop   (queue_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );
endmodule
